/* hdl/psa_pkg.sv */
package psa_pkg;

	// default build of the block
	localparam int WINDOW_LEN_DEF  = 60;
	localparam int SAMPLE_BITS_DEF = 12;

	// register field widths
	localparam int DBL_W     = 9;
	localparam int DBH_W     = 10;
	localparam int LIM_W     = 12;
	localparam int MINSPAN_W = 12;
	localparam int ERR_W     = 8;
	localparam int START_W   = 12;

	// result widths
	localparam int LEVEL_W  = 10;
	localparam int STATUS_W = 2;
	localparam int FAIL_W   = 8;

	// APB port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	// level mapping: [span_low, span_high] -> [-MAP_OFFSET, MAP_SCALE - MAP_OFFSET]
	localparam int MAP_SCALE   = 572;
	localparam int MAP_OFFSET  = 30;
	localparam int LEVEL_FULL  = 512;
	localparam int BAND_MARGIN = 20;
	localparam int SHRINK_STEP = 2;

	localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd0;
	localparam logic [STATUS_W-1:0] ST_READY   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

	// register reset values
	localparam logic [DBL_W-1:0]     DBL_RST        = 9'd20;
	localparam logic [DBH_W-1:0]     DBH_RST        = 10'd472;
	localparam logic [LIM_W-1:0]     LIM_RST        = 12'd60;
	localparam logic [MINSPAN_W-1:0] MINSPAN_RST    = 12'd1500;
	localparam logic [ERR_W-1:0]     ERR_RST        = 8'd100;
	localparam logic [START_W-1:0]   START_LOW_RST  = 12'd860;
	localparam logic [START_W-1:0]   START_HIGH_RST = 12'd2900;

	typedef enum logic [IDX_W-1:0] {
		REG_DB_LOW     = 3'd0,
		REG_DB_HIGH    = 3'd1,
		REG_STAB_LIM   = 3'd2,
		REG_MIN_SPAN   = 3'd3,
		REG_ERR_LIM    = 3'd4,
		REG_START_LOW  = 3'd5,
		REG_START_HIGH = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DBL_W-1:0]     db_low;
		logic [DBH_W-1:0]     db_high;
		logic [LIM_W-1:0]     stab_lim;
		logic [MINSPAN_W-1:0] min_span;
		logic [ERR_W-1:0]     err_lim;
		logic [START_W-1:0]   start_low;
		logic [START_W-1:0]   start_high;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic acc;        // take the input item into span and sums
		logic publish;    // update shown level/status and load the result
		logic mean;       // register the window mean
		logic prep;       // register the mapping numerator from the mean
		logic div_start;  // launch the mapping divide
		logic close;      // apply the window close
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;       // current item closes the window
		logic div_busy;
	} ctrl_sts_t;

endpackage

/* hdl/psa_div.sv */
module psa_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	// restoring divider, one quotient bit per cycle
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quot = quo_q;

endmodule

/* hdl/psa_datapath.sv */
module psa_datapath #(
	parameter int WINDOW_LEN  = psa_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psa_pkg::cfg_t                 cfg,
	input  psa_pkg::ctrl_cmd_t            cmd,
	output psa_pkg::ctrl_sts_t            sts,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic [psa_pkg::LEVEL_W-1:0]   level,
	output logic [psa_pkg::STATUS_W-1:0]  status,
	output logic                          changed,
	output logic                          window_end
);

	localparam int SPAN_W  = (SAMPLE_BITS > psa_pkg::START_W) ? SAMPLE_BITS : psa_pkg::START_W;
	localparam int CNT_W   = $clog2(WINDOW_LEN);
	localparam int N_W     = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int SQS_W   = 2 * SAMPLE_BITS + CNT_W;
	localparam int LHS_W   = SQS_W + N_W;
	localparam int SQ_W    = 2 * SUM_W;
	localparam int LIM2_W  = 2 * psa_pkg::LIM_W;
	localparam int TOL_W   = LIM2_W + 2 * N_W;
	localparam int CMP_A   = (LHS_W > SQ_W) ? LHS_W : SQ_W;
	localparam int CMP_W   = ((CMP_A > TOL_W) ? CMP_A : TOL_W) + 1;
	localparam int SCALE_W = $clog2(psa_pkg::MAP_SCALE + 1);
	localparam int DIV_W   = SPAN_W + SCALE_W;
	localparam int MAP_W   = DIV_W + 2;
	localparam int LV_W    = psa_pkg::LEVEL_W;
	localparam int BAND_W  = LV_W + 1;
	// mean = (sum * RCP) >> RCP_SH, exact for every reachable sum
	localparam int RCP_SH  = SUM_W + CNT_W;
	localparam int RCP_W   = SUM_W + 2;
	localparam int MPR_W   = SUM_W + RCP_W;

	localparam logic [N_W-1:0]     N_V   = N_W'(WINDOW_LEN);
	localparam logic [2*N_W-1:0]   N_SQ  = (2*N_W)'(WINDOW_LEN * WINDOW_LEN);
	localparam logic [CNT_W-1:0]   SLOT_LAST = CNT_W'(WINDOW_LEN - 1);
	localparam logic [SPAN_W-1:0]  SAMPLE_MAX = SPAN_W'((1 << SAMPLE_BITS) - 1);
	localparam logic [RCP_W-1:0]   RCP = RCP_W'(((64'd1 << RCP_SH) / WINDOW_LEN) + 64'd1);

	// accumulation and calibration state
	logic [SUM_W-1:0]          sum_q;
	logic [SQS_W-1:0]          sqsum_q;
	logic [CNT_W-1:0]          slot_q;
	logic [SPAN_W-1:0]         span_low_q;
	logic [SPAN_W-1:0]         span_high_q;
	logic                      range_ok_q;
	logic [psa_pkg::FAIL_W-1:0] fail_q;
	logic [LV_W-1:0]           calib_q;
	logic [LV_W-1:0]           shown_level_q;
	logic [psa_pkg::STATUS_W-1:0] shown_status_q;
	logic                      wend_q;
	logic                      out_changed_q;
	logic                      out_wend_q;

	// stability pipeline, recomputed every cycle from stable sums
	logic [LHS_W-1:0]  lhs_s1, lhs_s2;
	logic [SQ_W-1:0]   sq_s1, sq_s2;
	logic [LIM2_W-1:0] lim2_s1;
	logic [TOL_W-1:0]  tol_s2;
	logic              stable_s3;

	// window mean and mapping numerator
	logic [MPR_W-1:0]       mean_prod;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [DIV_W-1:0]       num_mag_q;
	logic                   num_neg_q;

	logic [2*SAMPLE_BITS-1:0] samp_sq;
	logic [SPAN_W-1:0]        samp_x;
	logic                     last;

	logic                    div_busy;
	logic [DIV_W-1:0]        div_quot;

	logic signed [SPAN_W:0]           diff;
	logic signed [SPAN_W+SCALE_W:0]   prod;
	logic signed [SPAN_W:0]           span_s;
	logic [SPAN_W-1:0]                span_mag;
	logic                             span_neg;
	logic                             span_zero;

	logic signed [DIV_W:0]   q_s;
	logic signed [MAP_W-1:0] mapped, m1, m2, m3;
	logic signed [MAP_W-1:0] dbl_s, dbh_s, full_s;
	logic [LV_W-1:0]         calib_d;
	logic                    in_band;
	logic                    good;

	logic [SPAN_W:0]          sl_up;
	logic [SPAN_W-1:0]        sl_new;
	logic signed [SPAN_W+1:0] sh_dn;
	logic [SPAN_W-1:0]        sh_new;
	logic [SPAN_W-1:0]        start_lo_x, start_hi_x;

	logic                    pub_ready, pub_err, restart;
	logic [LV_W-1:0]         new_level;
	logic [psa_pkg::STATUS_W-1:0] new_status;

	assign samp_sq    = sample * sample;
	assign samp_x     = SPAN_W'(sample);
	assign last       = slot_q == SLOT_LAST;
	assign start_lo_x = SPAN_W'(cfg.start_low);
	assign start_hi_x = SPAN_W'(cfg.start_high);
	assign mean_prod  = sum_q * RCP;

	always_ff @(posedge clk) begin
		lhs_s1    <= sqsum_q * N_V;
		sq_s1     <= sum_q * sum_q;
		lim2_s1   <= cfg.stab_lim * cfg.stab_lim;
		lhs_s2    <= lhs_s1;
		sq_s2     <= sq_s1;
		tol_s2    <= lim2_s1 * N_SQ;
		stable_s3 <= CMP_W'(lhs_s2) < (CMP_W'(sq_s2) + CMP_W'(tol_s2));
	end

	// signed span and mean offset
	always_comb begin
		span_s    = $signed({1'b0, span_high_q}) - $signed({1'b0, span_low_q});
		span_neg  = span_s[SPAN_W];
		span_zero = span_s == '0;
		span_mag  = span_neg ? SPAN_W'(-span_s) : SPAN_W'(span_s);
		diff      = $signed({1'b0, SPAN_W'(mean_q)}) - $signed({1'b0, span_low_q});
		prod      = diff * $signed({1'b0, SCALE_W'(psa_pkg::MAP_SCALE)});
	end

	always_ff @(posedge clk) begin
		if (cmd.mean) begin
			mean_q <= mean_prod[RCP_SH +: SAMPLE_BITS];
		end
		if (cmd.prep) begin
			num_neg_q <= prod[SPAN_W+SCALE_W];
			num_mag_q <= prod[SPAN_W+SCALE_W] ? DIV_W'(-prod) : DIV_W'(prod);
		end
	end

	psa_div #(
		.NUM_W(DIV_W),
		.DEN_W(SPAN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num_mag_q),
		.den   (span_mag),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	// window close: signed quotient, offset, deadband clamps
	always_comb begin
		dbl_s  = $signed(MAP_W'(cfg.db_low));
		dbh_s  = $signed(MAP_W'(cfg.db_high));
		full_s = $signed(MAP_W'(psa_pkg::LEVEL_FULL));
		q_s    = (num_neg_q ^ span_neg) ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
		if (span_zero) begin
			mapped = -$signed(MAP_W'(psa_pkg::MAP_OFFSET));
		end else begin
			mapped = $signed({q_s[DIV_W], q_s}) - $signed(MAP_W'(psa_pkg::MAP_OFFSET));
		end
		m1      = (mapped < dbl_s) ? '0 : mapped;
		m2      = (m1 > dbh_s) ? full_s : m1;
		m3      = (m2 > full_s) ? full_s : m2;
		calib_d = m3[LV_W-1:0];
		in_band = (BAND_W'(calib_d) + BAND_W'(psa_pkg::BAND_MARGIN)) > BAND_W'(cfg.db_low)
		          && BAND_W'(calib_d) < (BAND_W'(cfg.db_high) + BAND_W'(psa_pkg::BAND_MARGIN));
		good    = stable_s3 && (span_s > $signed({1'b0, SPAN_W'(cfg.min_span)}));
	end

	// span shrink toward the start bounds
	always_comb begin
		sl_up  = ({1'b0, span_low_q} < {1'b0, start_lo_x})
		         ? {1'b0, span_low_q} + (SPAN_W+1)'(psa_pkg::SHRINK_STEP)
		         : {1'b0, span_low_q};
		sl_new = (sl_up > {1'b0, start_lo_x}) ? start_lo_x : sl_up[SPAN_W-1:0];
		sh_dn  = (span_high_q > start_hi_x)
		         ? $signed({2'b0, span_high_q}) - $signed((SPAN_W+2)'(psa_pkg::SHRINK_STEP))
		         : $signed({2'b0, span_high_q});
		sh_new = (sh_dn < $signed({2'b0, start_hi_x})) ? start_hi_x : sh_dn[SPAN_W-1:0];
	end

	// publication
	always_comb begin
		pub_ready  = range_ok_q;
		pub_err    = !range_ok_q && (fail_q > cfg.err_lim) && (shown_status_q != psa_pkg::ST_ERROR);
		restart    = cmd.publish && pub_err;
		new_level  = shown_level_q;
		new_status = shown_status_q;
		if (pub_ready) begin
			new_level  = calib_q;
			new_status = psa_pkg::ST_READY;
		end else if (pub_err) begin
			new_level  = '0;
			new_status = psa_pkg::ST_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			sqsum_q        <= '0;
			slot_q         <= '0;
			span_low_q     <= SAMPLE_MAX;
			span_high_q    <= '0;
			range_ok_q     <= 1'b0;
			fail_q         <= '0;
			calib_q        <= '0;
			shown_level_q  <= '0;
			shown_status_q <= psa_pkg::ST_UNKNOWN;
			wend_q         <= 1'b0;
			out_changed_q  <= 1'b0;
			out_wend_q     <= 1'b0;
		end else begin
			if (restart) begin
				span_low_q  <= start_lo_x;
				span_high_q <= start_hi_x;
			end else if (cmd.close) begin
				if (good && in_band) begin
					span_low_q  <= sl_new;
					span_high_q <= sh_new;
				end
			end else if (cmd.acc) begin
				if (samp_x < span_low_q) begin
					span_low_q <= samp_x;
				end
				if (samp_x > span_high_q) begin
					span_high_q <= samp_x;
				end
			end

			if (restart || cmd.close) begin
				sum_q   <= '0;
				sqsum_q <= '0;
			end else if (cmd.acc) begin
				sum_q   <= sum_q + SUM_W'(sample);
				sqsum_q <= sqsum_q + SQS_W'(samp_sq);
			end

			if (restart) begin
				slot_q <= '0;
			end else if (cmd.acc) begin
				slot_q <= last ? '0 : slot_q + CNT_W'(1);
			end

			if (restart) begin
				range_ok_q <= 1'b0;
				fail_q     <= '0;
			end else if (cmd.close) begin
				range_ok_q <= good;
				if (good) begin
					fail_q <= '0;
				end else if (fail_q != '1) begin
					fail_q <= fail_q + psa_pkg::FAIL_W'(1);
				end
			end

			if (cmd.close) begin
				calib_q <= calib_d;
			end

			if (cmd.acc) begin
				wend_q <= last;
			end

			if (cmd.publish) begin
				shown_level_q  <= new_level;
				shown_status_q <= new_status;
				out_changed_q  <= (new_level != shown_level_q) || (new_status != shown_status_q);
				out_wend_q     <= cmd.acc ? last : wend_q;
			end
		end
	end

	assign sts.last     = last;
	assign sts.div_busy = div_busy;

	assign level      = shown_level_q;
	assign status     = shown_status_q;
	assign changed    = out_changed_q;
	assign window_end = out_wend_q;

endmodule

/* hdl/psa_ctrl.sv */
module psa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  psa_pkg::ctrl_sts_t sts,
	output psa_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b000_0001,
		S_MEAN    = 7'b000_0010,
		S_PREP    = 7'b000_0100,
		S_MAP_GO  = 7'b000_1000,
		S_MAP     = 7'b001_0000,
		S_CLOSE   = 7'b010_0000,
		S_PUB     = 7'b100_0000
	} state_t;

	state_t state_q, state_d;
	logic   ov_q;
	logic   out_free;

	// result slot is empty or being emptied this cycle
	assign out_free = !ov_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.acc = 1'b1;
					if (sts.last) begin
						state_d = S_MEAN;
					end else if (out_free) begin
						cmd.publish = 1'b1;
					end else begin
						state_d = S_PUB;
					end
				end
			end
			S_MEAN: begin
				cmd.mean = 1'b1;
				state_d  = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MAP_GO;
			end
			S_MAP_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_MAP;
			end
			S_MAP: begin
				if (!sts.div_busy) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = S_PUB;
			end
			S_PUB: begin
				if (out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= cmd.publish || (ov_q && out_stall);
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = ov_q;

endmodule

/* hdl/pedal_sensor_autocalibrator_core.sv */
// Pedal sensor auto-calibrator.
// Input items carry one raw ADC reading on sample (in_valid/in_stall); each
// yields exactly one result item (out_valid/out_stall) with level (0..512),
// status (unknown/ready/error), changed and window_end. Registers are to be
// written over the APB port only while no item is in flight; the block itself
// does not enforce this. pready is tied high.
//
// An item that does not close a window is taken and, when the result slot is
// free, its result is in the output register in the cycle after: one item per
// cycle inside a window while the output does not stall. Every WINDOW_LEN-th
// item closes the window: the controller steps through the mean (reciprocal
// multiply), the mapping numerator, the launch of the restoring divider, the
// divide (DIV_W = max(SAMPLE_BITS, 12) + 10 quotient bits), the close and the
// publish, with in_stall high meanwhile. A stalled result holds its payload;
// one more item is taken meanwhile, then in_stall stays high until the waiting
// result leaves. Reset clears the calibration state, sets the span to
// [max sample, 0] and loads the register defaults.
module pedal_sensor_autocalibrator_core #(
	parameter int WINDOW_LEN  = psa_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = psa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [SAMPLE_BITS-1:0]        sample,
	// result items
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [psa_pkg::LEVEL_W-1:0]   level,
	output logic [psa_pkg::STATUS_W-1:0]  status,
	output logic                          changed,
	output logic                          window_end,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psa_pkg::ADDR_W-1:0]    paddr,
	input  logic [psa_pkg::DATA_W-1:0]    pwdata,
	output logic [psa_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	psa_pkg::cfg_t      cfg_q;
	psa_pkg::ctrl_cmd_t cmd;
	psa_pkg::ctrl_sts_t sts;
	psa_pkg::reg_idx_t  reg_idx;
	logic               wr_en;

	// register file: word index from the byte address
	assign reg_idx = psa_pkg::reg_idx_t'(paddr[psa_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.db_low     <= psa_pkg::DBL_RST;
			cfg_q.db_high    <= psa_pkg::DBH_RST;
			cfg_q.stab_lim   <= psa_pkg::LIM_RST;
			cfg_q.min_span   <= psa_pkg::MINSPAN_RST;
			cfg_q.err_lim    <= psa_pkg::ERR_RST;
			cfg_q.start_low  <= psa_pkg::START_LOW_RST;
			cfg_q.start_high <= psa_pkg::START_HIGH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				psa_pkg::REG_DB_LOW:     cfg_q.db_low     <= pwdata[psa_pkg::DBL_W-1:0];
				psa_pkg::REG_DB_HIGH:    cfg_q.db_high    <= pwdata[psa_pkg::DBH_W-1:0];
				psa_pkg::REG_STAB_LIM:   cfg_q.stab_lim   <= pwdata[psa_pkg::LIM_W-1:0];
				psa_pkg::REG_MIN_SPAN:   cfg_q.min_span   <= pwdata[psa_pkg::MINSPAN_W-1:0];
				psa_pkg::REG_ERR_LIM:    cfg_q.err_lim    <= pwdata[psa_pkg::ERR_W-1:0];
				psa_pkg::REG_START_LOW:  cfg_q.start_low  <= pwdata[psa_pkg::START_W-1:0];
				psa_pkg::REG_START_HIGH: cfg_q.start_high <= pwdata[psa_pkg::START_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			psa_pkg::REG_DB_LOW:     prdata = psa_pkg::DATA_W'(cfg_q.db_low);
			psa_pkg::REG_DB_HIGH:    prdata = psa_pkg::DATA_W'(cfg_q.db_high);
			psa_pkg::REG_STAB_LIM:   prdata = psa_pkg::DATA_W'(cfg_q.stab_lim);
			psa_pkg::REG_MIN_SPAN:   prdata = psa_pkg::DATA_W'(cfg_q.min_span);
			psa_pkg::REG_ERR_LIM:    prdata = psa_pkg::DATA_W'(cfg_q.err_lim);
			psa_pkg::REG_START_LOW:  prdata = psa_pkg::DATA_W'(cfg_q.start_low);
			psa_pkg::REG_START_HIGH: prdata = psa_pkg::DATA_W'(cfg_q.start_high);
			default:                 prdata = '0;
		endcase
	end

	psa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	psa_datapath #(
		.WINDOW_LEN (WINDOW_LEN),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.sample    (sample),
		.level     (level),
		.status    (status),
		.changed   (changed),
		.window_end(window_end)
	);

	// an accepted item either yields a result next cycle or holds off input
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (out_valid || in_stall))
		else $error("accepted item neither published nor blocking input");

	// error state always shows a zero level
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == psa_pkg::ST_ERROR) |-> (level == '0))
		else $error("nonzero level in error status");

	// before the first good window the level stays zero
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == psa_pkg::ST_UNKNOWN) |-> (level == '0))
		else $error("nonzero level while status unknown");

	// a published level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level <= psa_pkg::LEVEL_W'(psa_pkg::LEVEL_FULL)))
		else $error("level above full scale");

endmodule
